### src/swcl_pkg.sv
// Shared types and constants of the sliding window counter limiter.
package swcl_pkg;

  localparam int CLIENT_W = 8;
  localparam int NOW_W    = 48;
  localparam int COUNT_W  = 16;
  localparam int WIN_W    = 32;
  localparam int PROD_W   = COUNT_W + WIN_W;
  localparam int ACC_W    = PROD_W + 1;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  localparam logic [COUNT_W-1:0] MAX_REQ_RST = 16'd100;
  localparam logic [WIN_W-1:0]   WINDOW_RST  = 32'd1000;

  typedef enum logic {
    REG_MAX_REQ = 1'b0,
    REG_WINDOW  = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_CHECK,
    ST_DIV,
    ST_ROLL,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_DECIDE,
    ST_OPEN,
    ST_RESULT
  } state_t;

  typedef enum logic [1:0] {
    MUL_PREV,
    MUL_CUR,
    MUL_LIMIT
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic     clr_step;
    logic     capture;
    logic     load;
    logic     check;
    logic     div_start;
    logic     div_step;
    logic     roll;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     decide;
    logic     open_entry;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic entry_valid;
    logic due;
    logic div_last;
    logic clr_last;
    logic out_busy;
  } sts_t;

endpackage

### src/swcl_ifs.sv
// Valid/ready channel interfaces for requests and results.
interface swcl_in_if;
  logic                          valid;
  logic                          ready;
  logic [swcl_pkg::CLIENT_W-1:0] client_index;
  logic [swcl_pkg::NOW_W-1:0]    now_ms;

  modport source (output valid, output client_index, output now_ms, input ready);
  modport sink (input valid, input client_index, input now_ms, output ready);
endinterface

interface swcl_out_if;
  logic                         valid;
  logic                         ready;
  logic                         allowed;
  logic [swcl_pkg::COUNT_W-1:0] current_count;

  modport source (output valid, output allowed, output current_count, input ready);
  modport sink (input valid, input allowed, input current_count, output ready);
endinterface

### src/swcl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/swcl_regs.sv
// APB configuration registers: request limit and window length.
module swcl_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swcl_pkg::APB_AW-1:0]   paddr,
  input  logic [swcl_pkg::APB_DW-1:0]   pwdata,
  output logic [swcl_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output logic [swcl_pkg::COUNT_W-1:0]  max_req,
  output logic [swcl_pkg::WIN_W-1:0]    window
);

  logic [swcl_pkg::COUNT_W-1:0] max_req_r, max_req_nxt;
  logic [swcl_pkg::WIN_W-1:0]   window_r, window_nxt;
  swcl_pkg::reg_idx_t           sel;
  logic                         wr_en;

  assign sel    = swcl_pkg::reg_idx_t'(paddr[2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    max_req_nxt = max_req_r;
    window_nxt  = window_r;
    prdata      = '0;
    unique case (sel)
      swcl_pkg::REG_MAX_REQ: begin
        prdata = swcl_pkg::APB_DW'(max_req_r);
        if (wr_en) max_req_nxt = pwdata[swcl_pkg::COUNT_W-1:0];
      end
      swcl_pkg::REG_WINDOW: begin
        prdata = swcl_pkg::APB_DW'(window_r);
        if (wr_en) window_nxt = pwdata[swcl_pkg::WIN_W-1:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_req_r <= swcl_pkg::MAX_REQ_RST;
      window_r  <= swcl_pkg::WINDOW_RST;
    end else begin
      max_req_r <= max_req_nxt;
      window_r  <= window_nxt;
    end
  end

  assign max_req = max_req_r;
  assign window  = window_r;

endmodule

### src/swcl_ctrl.sv
// Request sequencer: table clear, lookup, rollover divide, weighted test, result.
module swcl_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           out_ready,
  input  swcl_pkg::sts_t sts,
  output logic           in_ready,
  output swcl_pkg::cmd_t cmd
);

  swcl_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swcl_pkg::ST_CLEAR:  if (sts.clr_last) state_nxt = swcl_pkg::ST_IDLE;
      swcl_pkg::ST_IDLE:   if (in_valid) state_nxt = swcl_pkg::ST_READ;
      swcl_pkg::ST_READ:   state_nxt = sts.in_range ? swcl_pkg::ST_LOAD : swcl_pkg::ST_RESULT;
      swcl_pkg::ST_LOAD:   state_nxt = swcl_pkg::ST_CHECK;
      swcl_pkg::ST_CHECK: begin
        if (!sts.entry_valid)  state_nxt = swcl_pkg::ST_OPEN;
        else if (sts.due)      state_nxt = swcl_pkg::ST_DIV;
        else                   state_nxt = swcl_pkg::ST_MUL_A;
      end
      swcl_pkg::ST_DIV:    if (sts.div_last) state_nxt = swcl_pkg::ST_ROLL;
      swcl_pkg::ST_ROLL:   state_nxt = swcl_pkg::ST_MUL_A;
      swcl_pkg::ST_MUL_A:  state_nxt = swcl_pkg::ST_MUL_B;
      swcl_pkg::ST_MUL_B:  state_nxt = swcl_pkg::ST_MUL_C;
      swcl_pkg::ST_MUL_C:  state_nxt = swcl_pkg::ST_DECIDE;
      swcl_pkg::ST_DECIDE: state_nxt = swcl_pkg::ST_RESULT;
      swcl_pkg::ST_OPEN:   state_nxt = swcl_pkg::ST_RESULT;
      swcl_pkg::ST_RESULT: if (!sts.out_busy || out_ready) state_nxt = swcl_pkg::ST_IDLE;
      default:             state_nxt = swcl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      swcl_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
      swcl_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      swcl_pkg::ST_LOAD: cmd.load = 1'b1;
      swcl_pkg::ST_CHECK: begin
        cmd.check     = 1'b1;
        cmd.div_start = 1'b1;
      end
      swcl_pkg::ST_DIV:  cmd.div_step = 1'b1;
      swcl_pkg::ST_ROLL: cmd.roll = 1'b1;
      swcl_pkg::ST_MUL_A: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = swcl_pkg::MUL_PREV;
      end
      swcl_pkg::ST_MUL_B: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = swcl_pkg::MUL_CUR;
        cmd.acc_op  = swcl_pkg::ACC_LOAD;
      end
      swcl_pkg::ST_MUL_C: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = swcl_pkg::MUL_LIMIT;
        cmd.acc_op  = swcl_pkg::ACC_ADD;
      end
      swcl_pkg::ST_DECIDE: cmd.decide = 1'b1;
      swcl_pkg::ST_OPEN:   cmd.open_entry = 1'b1;
      swcl_pkg::ST_RESULT: cmd.out_load = !sts.out_busy || out_ready;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swcl_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### src/swcl_dp.sv
// Datapath: client table, elapsed time, restoring divider, shared multiplier, result register.
module swcl_dp #(
  parameter int CLIENTS   = 256,
  parameter int TIME_BITS = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  swcl_pkg::cmd_t                cmd,
  output swcl_pkg::sts_t                sts,
  input  logic [swcl_pkg::CLIENT_W-1:0] in_client_index,
  input  logic [swcl_pkg::NOW_W-1:0]    in_now_ms,
  input  logic [swcl_pkg::COUNT_W-1:0]  max_req,
  input  logic [swcl_pkg::WIN_W-1:0]    window,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_allowed,
  output logic [swcl_pkg::COUNT_W-1:0]  out_count
);

  localparam int IDX_W = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int CNT_W = $clog2(TIME_BITS);
  localparam int CW    = swcl_pkg::COUNT_W;
  localparam int WW    = swcl_pkg::WIN_W;
  localparam int DW    = 2 * CW + TIME_BITS;
  localparam logic [16:0] CLIENTS_L = 17'(CLIENTS);

  // request
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic                 range_r, range_nxt;
  // entry under work
  logic                 vld_r, vld_nxt;
  logic [CW-1:0]        prev_r, prev_nxt;
  logic [CW-1:0]        cur_r, cur_nxt;
  logic [TIME_BITS-1:0] start_r, start_nxt;
  logic [TIME_BITS-1:0] elapsed_r, elapsed_nxt;
  logic [WW-1:0]        w_r, w_nxt;
  logic [WW-1:0]        diff_r, diff_nxt;
  // divider
  logic [TIME_BITS-1:0] dvd_r, dvd_nxt;
  logic [WW-1:0]        rem_r, rem_nxt;
  logic [TIME_BITS-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  // weighted test
  logic [swcl_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [swcl_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  // result
  logic                 res_allowed_r, res_allowed_nxt;
  logic [CW-1:0]        res_count_r, res_count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_allowed_r, out_allowed_nxt;
  logic [CW-1:0]        out_count_r, out_count_nxt;
  logic [IDX_W-1:0]     clr_cnt_r, clr_cnt_nxt;

  logic [DW-1:0]        drd, dwr;
  logic                 vrd;
  logic                 dwe, vwe;
  logic [IDX_W-1:0]     vwaddr;
  logic [TIME_BITS-1:0] rd_start;
  logic [WW:0]          div_try, div_sub;
  logic                 div_ge;
  logic [CW-1:0]        mul_a;
  logic [WW-1:0]        mul_b;
  logic                 allow;
  logic [CW-1:0]        cur_inc;

  // entry_valid is cleared by the sweep after reset; the count/start store is not
  swcl_ram #(.WIDTH(1), .DEPTH(CLIENTS)) u_valid_ram (
    .clk   (clk),
    .we    (vwe),
    .waddr (vwaddr),
    .wdata (cmd.open_entry),
    .raddr (idx_r),
    .rdata (vrd)
  );

  swcl_ram #(.WIDTH(DW), .DEPTH(CLIENTS)) u_entry_ram (
    .clk   (clk),
    .we    (dwe),
    .waddr (idx_r),
    .wdata (dwr),
    .raddr (idx_r),
    .rdata (drd)
  );

  assign vwe    = cmd.clr_step | cmd.open_entry;
  assign vwaddr = cmd.clr_step ? clr_cnt_r : idx_r;
  assign dwe    = cmd.open_entry | cmd.decide;
  assign dwr    = cmd.open_entry ? {CW'(0), CW'(1), now_r} : {prev_r, cur_inc, start_r};

  assign rd_start = drd[TIME_BITS-1:0];

  // one quotient bit per cycle; partial remainder always below the window
  assign div_try = {rem_r, dvd_r[TIME_BITS-1]};
  assign div_sub = div_try - {1'b0, w_r};
  assign div_ge  = div_try >= {1'b0, w_r};

  always_comb begin
    case (cmd.mul_sel)
      swcl_pkg::MUL_PREV: mul_a = prev_r;
      swcl_pkg::MUL_CUR:  mul_a = cur_r;
      default:            mul_a = max_req;
    endcase
  end
  assign mul_b = (cmd.mul_sel == swcl_pkg::MUL_PREV) ? diff_r : w_r;

  // prev*(W-e) + cur*W < max*W
  assign allow   = acc_r < swcl_pkg::ACC_W'(prod_r);
  assign cur_inc = (allow && cur_r != '1) ? cur_r + CW'(1) : cur_r;

  always_comb begin
    idx_nxt         = idx_r;
    now_nxt         = now_r;
    range_nxt       = range_r;
    vld_nxt         = vld_r;
    prev_nxt        = prev_r;
    cur_nxt         = cur_r;
    start_nxt       = start_r;
    elapsed_nxt     = elapsed_r;
    w_nxt           = w_r;
    diff_nxt        = diff_r;
    dvd_nxt         = dvd_r;
    rem_nxt         = rem_r;
    quo_nxt         = quo_r;
    cnt_nxt         = cnt_r;
    prod_nxt        = prod_r;
    acc_nxt         = acc_r;
    res_allowed_nxt = res_allowed_r;
    res_count_nxt   = res_count_r;
    out_allowed_nxt = out_allowed_r;
    out_count_nxt   = out_count_r;

    if (cmd.capture) begin
      idx_nxt         = IDX_W'(in_client_index);
      now_nxt         = TIME_BITS'(in_now_ms);
      range_nxt       = 17'(in_client_index) < CLIENTS_L;
      res_allowed_nxt = 1'b0;
      res_count_nxt   = '0;
    end
    if (cmd.load) begin
      vld_nxt     = vrd;
      prev_nxt    = drd[DW-1 -: CW];
      cur_nxt     = drd[TIME_BITS +: CW];
      start_nxt   = rd_start;
      // time going backwards counts as no time elapsed
      elapsed_nxt = (now_r >= rd_start) ? now_r - rd_start : '0;
      w_nxt       = (window == '0) ? WW'(1) : window;
    end
    if (cmd.check) begin
      diff_nxt = w_r - elapsed_r[WW-1:0];
    end
    if (cmd.div_start) begin
      dvd_nxt = elapsed_r;
      rem_nxt = '0;
      quo_nxt = '0;
      cnt_nxt = '0;
    end
    if (cmd.div_step) begin
      dvd_nxt = dvd_r << 1;
      rem_nxt = div_ge ? div_sub[WW-1:0] : div_try[WW-1:0];
      quo_nxt = {quo_r[TIME_BITS-2:0], div_ge};
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    if (cmd.roll) begin
      // start + n*W equals now - (elapsed mod W)
      prev_nxt  = (quo_r == TIME_BITS'(1)) ? cur_r : '0;
      cur_nxt   = '0;
      start_nxt = now_r - TIME_BITS'(rem_r);
      diff_nxt  = w_r - rem_r;
    end
    if (cmd.mul_en) begin
      prod_nxt = swcl_pkg::PROD_W'(mul_a) * swcl_pkg::PROD_W'(mul_b);
    end
    case (cmd.acc_op)
      swcl_pkg::ACC_LOAD: acc_nxt = swcl_pkg::ACC_W'(prod_r);
      swcl_pkg::ACC_ADD:  acc_nxt = acc_r + swcl_pkg::ACC_W'(prod_r);
      default:            acc_nxt = acc_r;
    endcase
    if (cmd.decide) begin
      cur_nxt         = cur_inc;
      res_allowed_nxt = allow;
      res_count_nxt   = cur_inc;
    end
    if (cmd.open_entry) begin
      res_allowed_nxt = 1'b1;
      res_count_nxt   = CW'(1);
    end
    if (cmd.out_load) begin
      out_allowed_nxt = res_allowed_r;
      out_count_nxt   = res_count_r;
    end
  end

  assign out_valid_nxt = cmd.out_load | (out_valid_r & ~out_ready);
  assign clr_cnt_nxt   = cmd.clr_step ? clr_cnt_r + IDX_W'(1) : clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      clr_cnt_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    now_r         <= now_nxt;
    range_r       <= range_nxt;
    vld_r         <= vld_nxt;
    prev_r        <= prev_nxt;
    cur_r         <= cur_nxt;
    start_r       <= start_nxt;
    elapsed_r     <= elapsed_nxt;
    w_r           <= w_nxt;
    diff_r        <= diff_nxt;
    dvd_r         <= dvd_nxt;
    rem_r         <= rem_nxt;
    quo_r         <= quo_nxt;
    cnt_r         <= cnt_nxt;
    prod_r        <= prod_nxt;
    acc_r         <= acc_nxt;
    res_allowed_r <= res_allowed_nxt;
    res_count_r   <= res_count_nxt;
    out_allowed_r <= out_allowed_nxt;
    out_count_r   <= out_count_nxt;
  end

  assign sts.in_range    = range_r;
  assign sts.entry_valid = vld_r;
  assign sts.due         = elapsed_r >= TIME_BITS'(w_r);
  assign sts.div_last    = cnt_r == CNT_W'(TIME_BITS - 1);
  assign sts.clr_last    = clr_cnt_r == IDX_W'(CLIENTS - 1);
  assign sts.out_busy    = out_valid_r;

  assign out_valid   = out_valid_r;
  assign out_allowed = out_allowed_r;
  assign out_count   = out_count_r;

endmodule

### src/sliding_window_counter_limiter.sv
// Sliding window counter rate limiter: one verdict per request, per-client window state in RAM.
// After reset the block sweeps the client valid table and takes no request meanwhile. A request
// is then processed alone: a first request on a client opens its entry, a request within its window
// takes three passes through one shared 16x32 multiplier, and a request that rolls the window over
// first runs the bit-per-cycle restoring divider that finds elapsed mod window, followed by the same
// three passes. The result sits in an output register, so the next request is taken while the
// last verdict still waits for its transfer.
module sliding_window_counter_limiter #(
  parameter int CLIENTS   = 256,
  parameter int TIME_BITS = 48
) (
  input  logic                             clk,
  input  logic                             rst_n,
  swcl_in_if.sink                          in_ch,
  swcl_out_if.source                       out_ch,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [swcl_pkg::APB_AW-1:0]      cfg_paddr,
  input  logic [swcl_pkg::APB_DW-1:0]      cfg_pwdata,
  output logic [swcl_pkg::APB_DW-1:0]      cfg_prdata,
  output logic                             cfg_pready
);

  swcl_pkg::cmd_t               cmd;
  swcl_pkg::sts_t               sts;
  logic [swcl_pkg::COUNT_W-1:0] max_req;
  logic [swcl_pkg::WIN_W-1:0]   window;
  logic                         in_ready;

  swcl_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .max_req (max_req),
    .window  (window)
  );

  swcl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  swcl_dp #(.CLIENTS(CLIENTS), .TIME_BITS(TIME_BITS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_client_index (in_ch.client_index),
    .in_now_ms       (in_ch.now_ms),
    .max_req         (max_req),
    .window          (window),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_allowed     (out_ch.allowed),
    .out_count       (out_ch.current_count)
  );

  assign in_ch.ready = in_ready;

`ifndef SYNTH
  // an admitted request always leaves a nonzero count
  a_allowed_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (!out_ch.allowed || out_ch.current_count != '0))
    else $error("admitted result with zero count");

  // one request at a time: no second transfer right after one
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_ch.valid && in_ch.ready && rst_n) |-> !in_ch.ready)
    else $error("input ready right after a transfer");

  // the divider runs only for a known client in range
  a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (sts.entry_valid && sts.in_range))
    else $error("divider step without a valid entry");
`endif

endmodule
